@@ rtl/rlda_pkg.sv @@
// Shared types and constants for the RTCP loss delta aggregator.
// Used by rlda_ctrl, rlda_dpath and rtcp_loss_delta_aggregator_core.
`default_nettype none

package rlda_pkg;

  // Default depth of the source table.
  localparam int TableEntriesDefault = 16;

  // Field widths.
  localparam int SrcW    = 32;
  localparam int SeqW    = 32;
  localparam int LostW   = 32;
  localparam int TimeW   = 48;
  localparam int RecvW   = 31;

  // Packed word widths on the stream ports.
  localparam int InDataW  = SrcW + SeqW + LostW + TimeW;          // 144
  localparam int OutBitsW = LostW + RecvW + TimeW + TimeW;        // 159
  localparam int OutDataW = ((OutBitsW + 7) / 8) * 8;             // 160

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input word and start the table scan
    logic rd_entry;  // read the stored sequence and loss of the matching entry
    logic acc;       // add the differences to the sums and rewrite the entry
    logic alloc;     // store a new source in the lowest free entry
    logic close;     // end of report: clear sums, update window end on pass
    logic emit;      // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done; // the last table entry is being compared this cycle
    logic hit;       // the source was found in the table
    logic free;      // a free entry exists
    logic last;      // the captured word is the last block of a report
    logic pass;      // the sums pass the loss report checks
    logic ctrl;      // a congestion controller is present
    logic out_busy;  // the result register holds a word that is not taken
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/rtcp_loss_delta_aggregator_core.sv @@
// Top level of the RTCP loss delta aggregator.
// Depends on rlda_pkg, rlda_ctrl and rlda_dpath.
//
// Usage: receiver report blocks enter as words on the s_axis channel, one
// block per word, with s_axis_tlast marking the last block of a report. Each
// block is looked up in a table of TABLE_ENTRIES sources by a scan that reads
// one source entry per cycle from the table memory. A known source adds its
// sequence and loss differences to running sums; an unknown one is stored in
// the lowest free entry when there is room. On the last block the sums are
// checked and, when they pass and a controller is present (cfg_wr_en /
// cfg_wr_data), one loss report word leaves on m_axis.
// The block takes a new word only when it is through with the previous one,
// and the table scan sets the pace at which words are taken.
// The result sits in an output register, so a stalled receiver does not stop
// the intake; only a second result that is due while the first is still
// held waits, and the intake waits with it.
// Reset (rst, synchronous) clears the table valid bits, the sums, the window
// end time and the controller flag; no clearing pass is needed.
`default_nettype none

module rtcp_loss_delta_aggregator_core import rlda_pkg::*; #(
  parameter int TABLE_ENTRIES = TableEntriesDefault
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_wr_en,
  input  wire                 cfg_wr_data,    // controller_present
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  // Fields from bit 0 up: source_id[31:0], highest_seq[63:32],
  // cumulative_lost[95:64], now_ms[143:96].
  input  wire  [InDataW-1:0]  s_axis_tdata,
  input  wire                 s_axis_tlast,   // last_block
  output logic                m_axis_tvalid,
  input  wire                 m_axis_tready,
  // Fields from bit 0 up: lost change[31:0], received_delta[62:32],
  // window_start_ms[110:63], window_end_ms[158:111], bit 159 zero.
  output logic [OutDataW-1:0] m_axis_tdata
);

  cmd_t cmd;
  sts_t sts;

  // The controller sequences scan, lookup, update and report close.
  rlda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the table memories, the sums and the result register.
  rlda_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (s_axis_tdata),
    .in_last     (s_axis_tlast),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_data    (m_axis_tdata),
    .cmd         (cmd),
    .sts         (sts)
  );

  // After a word is taken the block is busy with it and not ready in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a block was still in work");

  // A result is only produced on a passing last block with a controller.
  a_emit_cond: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (sts.last && sts.pass && sts.ctrl && cmd.close))
    else $error("result produced without a passing last block");

  // A new result never overwrites one the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

@@ rtl/rlda_ctrl.sv @@
// Controller state machine of the RTCP loss delta aggregator.
// Depends on rlda_pkg for the command and status structs.
`default_nettype none

module rlda_ctrl import rlda_pkg::*; (
  input  wire       clk,
  input  wire       rst,
  input  wire       in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_LOOKUP = 5'b00100,
    S_ACC    = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (sts.hit) begin
          cmd.rd_entry = 1'b1;
          state_next   = S_ACC;
        end else begin
          cmd.alloc  = sts.free;
          state_next = S_FINISH;
        end
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!sts.last) begin
          state_next = S_IDLE;
        end else if (!(sts.pass && sts.ctrl && sts.out_busy)) begin
          // Wait only when a result is due and the previous one is still held.
          cmd.close  = 1'b1;
          cmd.emit   = sts.pass && sts.ctrl;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/rlda_dpath.sv @@
// Datapath of the RTCP loss delta aggregator: source table, sums, result register.
// Depends on rlda_pkg; driven by commands from rlda_ctrl.
`default_nettype none

module rlda_dpath import rlda_pkg::*; #(
  parameter int TABLE_ENTRIES = TableEntriesDefault
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_wr_en,
  input  wire                 cfg_wr_data,
  input  wire  [InDataW-1:0]  in_data,
  input  wire                 in_last,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [OutDataW-1:0] out_data,
  input  wire cmd_t           cmd,
  output sts_t                sts
);

  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  // Captured input word.
  logic [SrcW-1:0]  in_src;
  logic [SeqW-1:0]  in_seq;
  logic [LostW-1:0] in_lost;
  logic [TimeW-1:0] in_now;
  logic             in_last_q;

  logic controller_present;

  // Table storage.
  logic [TABLE_ENTRIES-1:0] valid_bits;
  logic [SrcW-1:0]  src_mem  [TABLE_ENTRIES];
  logic [SeqW-1:0]  seq_mem  [TABLE_ENTRIES];
  logic [LostW-1:0] lost_mem [TABLE_ENTRIES];

  // Scan pipeline.
  logic            rd_busy;
  logic [IdxW-1:0] rd_idx;
  logic            cmp_vld;
  logic [IdxW-1:0] cmp_idx;
  logic [SrcW-1:0] src_rd;
  logic            vld_rd;
  logic            hit_found;
  logic [IdxW-1:0] hit_idx;
  logic            free_found;
  logic [IdxW-1:0] free_idx;

  logic [SeqW-1:0]  seq_rd;
  logic [LostW-1:0] lost_rd;

  logic [SeqW-1:0]  sum_seq;
  logic [LostW-1:0] sum_lost;
  logic [TimeW-1:0] last_window_end;

  logic [SeqW-1:0] recv;
  logic            pass;
  logic [IdxW-1:0] wr_idx;

  logic [LostW-1:0] out_lost;
  logic [RecvW-1:0] out_recv;
  logic [TimeW-1:0] out_start;
  logic [TimeW-1:0] out_end;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_src    <= in_data[SrcW-1:0];
      in_seq    <= in_data[SrcW+SeqW-1:SrcW];
      in_lost   <= in_data[SrcW+SeqW+LostW-1:SrcW+SeqW];
      in_now    <= in_data[InDataW-1:SrcW+SeqW+LostW];
      in_last_q <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      controller_present <= 1'b0;
    end else if (cfg_wr_en) begin
      controller_present <= cfg_wr_data;
    end
  end

  // Scan control: one entry read per cycle, compared in the following cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_busy    <= 1'b0;
      rd_idx     <= '0;
      cmp_vld    <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (cmd.load) begin
        rd_busy    <= 1'b1;
        rd_idx     <= '0;
        hit_found  <= 1'b0;
        free_found <= 1'b0;
      end else if (rd_busy) begin
        if (rd_idx == LastIdx) begin
          rd_busy <= 1'b0;
        end else begin
          rd_idx <= rd_idx + 1'b1;
        end
      end
      cmp_vld <= rd_busy && !cmd.load;
      if (cmp_vld) begin
        if (vld_rd && !hit_found && (src_rd == in_src)) begin
          hit_found <= 1'b1;
        end
        if (!vld_rd && !free_found) begin
          free_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_busy) begin
      src_rd  <= src_mem[rd_idx];
      vld_rd  <= valid_bits[rd_idx];
      cmp_idx <= rd_idx;
    end
    if (cmp_vld) begin
      if (vld_rd && !hit_found && (src_rd == in_src)) begin
        hit_idx <= cmp_idx;
      end
      if (!vld_rd && !free_found) begin
        free_idx <= cmp_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (cmd.alloc) begin
      valid_bits[free_idx] <= 1'b1;
    end
  end

  assign wr_idx = cmd.alloc ? free_idx : hit_idx;

  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      src_mem[free_idx] <= in_src;
    end
    if (cmd.alloc || cmd.acc) begin
      seq_mem[wr_idx]  <= in_seq;
      lost_mem[wr_idx] <= in_lost;
    end
    if (cmd.rd_entry) begin
      seq_rd  <= seq_mem[hit_idx];
      lost_rd <= lost_mem[hit_idx];
    end
  end

  assign recv = sum_seq - sum_lost;
  assign pass = (sum_seq != '0) && (recv != '0) && !recv[SeqW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_seq         <= '0;
      sum_lost        <= '0;
      last_window_end <= '0;
    end else if (cmd.close) begin
      sum_seq  <= '0;
      sum_lost <= '0;
      if (pass) begin
        last_window_end <= in_now;
      end
    end else if (cmd.acc) begin
      sum_seq  <= sum_seq + (in_seq - seq_rd);
      sum_lost <= sum_lost + (in_lost - lost_rd);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_lost  <= sum_lost;
      out_recv  <= recv[RecvW-1:0];
      out_start <= last_window_end;
      out_end   <= in_now;
    end
  end

  assign out_data = {{(OutDataW - OutBitsW){1'b0}}, out_end, out_start, out_recv, out_lost};

  always_comb begin
    sts.scan_done = cmp_vld && (cmp_idx == LastIdx);
    sts.hit       = hit_found;
    sts.free      = free_found;
    sts.last      = in_last_q;
    sts.pass      = pass;
    sts.ctrl      = controller_present;
    sts.out_busy  = out_valid && !out_ready;
  end

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking bench for rtcp_loss_delta_aggregator_core: report block words
// go in on s_axis, loss report words are checked on m_axis against a predictor.
// Depends on rlda_pkg and the core RTL only.
`timescale 1ns / 100ps

module testbench;
  import rlda_pkg::*;

  localparam int PoolSize     = TableEntriesDefault;
  localparam int SettleCycles = 2 * (TableEntriesDefault + 5);

  // One receiver report block, plus a flag that makes the sender wait until
  // every loss report already due has arrived before it offers this word.
  typedef struct packed {
    logic             hold;
    logic             last_block;
    logic [TimeW-1:0] now_ms;
    logic [LostW-1:0] cum_lost;
    logic [SeqW-1:0]  highest_seq;
    logic [SrcW-1:0]  source_id;
  } rr_block_t;

  // Laid out to match m_axis_tdata, lowest field last.
  typedef struct packed {
    logic [TimeW-1:0] win_end;
    logic [TimeW-1:0] win_start;
    logic [RecvW-1:0] received_delta;
    logic [LostW-1:0] lost_chg;
  } loss_report_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_HEAVY} rx_stall_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic                cfg_wr_data = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  rtcp_loss_delta_aggregator_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // Predictor state: a mirror of the source table, the running sums and the
  // stored window end, plus the controller flag as last written.
  logic             tbl_valid [PoolSize];
  logic [SrcW-1:0]  tbl_src   [PoolSize];
  logic [SeqW-1:0]  tbl_seq   [PoolSize];
  logic [LostW-1:0] tbl_lost  [PoolSize];
  logic [SeqW-1:0]  acc_seq = '0;
  logic [LostW-1:0] acc_lost = '0;
  logic [TimeW-1:0] win_end_ms = '0;
  logic             ctrl_on = 1'b0;

  rr_block_t    report_blocks_to_send[$];
  loss_report_t loss_reports_due[$];

  // Stimulus bookkeeping: the sources the table will hold and the sequence
  // and loss values last sent for each of them.
  logic [SrcW-1:0]  pool_src  [PoolSize];
  logic [SeqW-1:0]  pool_seq  [PoolSize];
  logic [LostW-1:0] pool_lost [PoolSize];
  logic [TimeW-1:0] clock_ms = '0;
  bit               hold_next = 1'b0;
  int               n_useful = 0;

  int n_errors = 0;
  int n_accepted = 0;
  int n_reports = 0;
  int n_cfg_writes = 0;

  initial begin
    for (int i = 0; i < PoolSize; i++) tbl_valid[i] = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    n_errors++;
  endtask

  // Applies one block to the mirrored state and returns 1 when it yields a
  // loss report, which is then left in rep.
  function automatic bit predict_loss_report(input rr_block_t blk,
                                             output loss_report_t rep);
    int         hit;
    int         free_idx;
    logic [31:0] recv;
    bit         passed;
    hit = -1;
    free_idx = -1;
    rep = '0;
    predict_loss_report = 1'b0;
    for (int i = 0; i < PoolSize; i++) begin
      if (tbl_valid[i]) begin
        if (hit < 0 && tbl_src[i] == blk.source_id) hit = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    if (hit >= 0) begin
      acc_seq  = acc_seq + (blk.highest_seq - tbl_seq[hit]);
      acc_lost = acc_lost + (blk.cum_lost - tbl_lost[hit]);
      tbl_seq[hit]  = blk.highest_seq;
      tbl_lost[hit] = blk.cum_lost;
    end else if (free_idx >= 0) begin
      tbl_valid[free_idx] = 1'b1;
      tbl_src[free_idx]   = blk.source_id;
      tbl_seq[free_idx]   = blk.highest_seq;
      tbl_lost[free_idx]  = blk.cum_lost;
    end
    if (blk.last_block) begin
      // Received count is read as a signed 32-bit value and must be >= 1.
      recv = acc_seq - acc_lost;
      passed = (acc_seq != '0) && (recv != '0) && !recv[31];
      if (passed) begin
        if (ctrl_on) begin
          rep.lost_chg       = acc_lost;
          rep.received_delta = recv[RecvW-1:0];
          rep.win_start      = win_end_ms;
          rep.win_end        = blk.now_ms;
          predict_loss_report = 1'b1;
        end
        win_end_ms = blk.now_ms;
      end
      acc_seq  = '0;
      acc_lost = '0;
    end
  endfunction

  // Sender: bursts of words with random gaps, fed from the pending queue.
  int        burst_left = 1;
  int        gap_left = 0;
  rr_block_t cur_blk;

  always @(posedge clk) begin
    logic         launch;
    loss_report_t rep;
    launch = 1'b0;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        n_accepted++;
        if (predict_loss_report(cur_blk, rep))
          loss_reports_due.insert(loss_reports_due.size(), rep);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (report_blocks_to_send.size() > 0 &&
                     !(report_blocks_to_send[0].hold && loss_reports_due.size() > 0)) begin
          cur_blk = report_blocks_to_send.pop_front();
          launch = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
          end
        end
        s_axis_tvalid <= launch;
        if (launch) begin
          s_axis_tdata <= {cur_blk.now_ms, cur_blk.cum_lost, cur_blk.highest_seq,
                           cur_blk.source_id};
          s_axis_tlast <= cur_blk.last_block;
        end
      end
    end
  end

  // Receiver: switches between open, randomly stalled and mostly stalled
  // stretches, and checks every loss report word it takes.
  rx_stall_t rx_mode = RX_OPEN;
  int        rx_left = 0;

  always @(posedge clk) begin
    loss_report_t got;
    loss_report_t want;
    logic         ready_nxt;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = loss_report_t'(m_axis_tdata[OutBitsW-1:0]);
        if (loss_reports_due.size() == 0) begin
          flag_mismatch($sformatf("loss report with none due: %h", m_axis_tdata));
        end else begin
          want = loss_reports_due.pop_front();
          n_reports++;
          if (got.lost_chg !== want.lost_chg)
            flag_mismatch($sformatf("lost change got %0d want %0d",
                                    $signed(got.lost_chg), $signed(want.lost_chg)));
          if (got.received_delta !== want.received_delta)
            flag_mismatch($sformatf("received_delta got %0d want %0d",
                                    got.received_delta, want.received_delta));
          if (got.win_start !== want.win_start)
            flag_mismatch($sformatf("window_start_ms got %0d want %0d",
                                    got.win_start, want.win_start));
          if (got.win_end !== want.win_end)
            flag_mismatch($sformatf("window_end_ms got %0d want %0d",
                                    got.win_end, want.win_end));
        end
      end
      if (rx_left == 0) begin
        rx_mode = rx_stall_t'($urandom_range(0, 2));
        rx_left = $urandom_range(20, 300);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_OPEN:   ready_nxt = 1'b1;
        RX_RANDOM: ready_nxt = 1'($urandom_range(0, 1));
        default:   ready_nxt = ($urandom_range(0, 7) == 0);
      endcase
      m_axis_tready <= ready_nxt;
    end
  end

  function automatic logic [TimeW-1:0] rand48();
    return TimeW'({$urandom, $urandom});
  endfunction

  task automatic queue_block(input logic [SrcW-1:0] src, input logic [SeqW-1:0] seq,
                             input logic [LostW-1:0] lost, input logic [TimeW-1:0] now,
                             input logic last);
    rr_block_t blk;
    blk.hold        = hold_next;
    blk.last_block  = last;
    blk.now_ms      = now;
    blk.cum_lost    = lost;
    blk.highest_seq = seq;
    blk.source_id   = src;
    hold_next = 1'b0;
    report_blocks_to_send.insert(report_blocks_to_send.size(), blk);
  endtask

  // Advances the sequence and loss of one pool source and queues its block.
  task automatic queue_pool(input int idx, input logic [SeqW-1:0] seq_step,
                            input logic [LostW-1:0] lost_step, input logic last,
                            input logic [TimeW-1:0] now);
    pool_seq[idx]  = pool_seq[idx] + seq_step;
    pool_lost[idx] = pool_lost[idx] + lost_step;
    n_useful++;
    queue_block(pool_src[idx], pool_seq[idx], pool_lost[idx], now, last);
  endtask

  // Receive time for the closing block of a report: mostly advancing, now and
  // then a jump anywhere or to one of the extremes.
  function automatic logic [TimeW-1:0] next_report_ms();
    case ($urandom_range(0, 31))
      0:       clock_ms = '0;
      1:       clock_ms = '1;
      2, 3:    clock_ms = rand48();
      default: clock_ms = clock_ms + $urandom_range(1, 5000);
    endcase
    return clock_ms;
  endfunction

  task automatic set_controller(input logic on);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= on;
    ctrl_on = on;
    n_cfg_writes++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Waits until every word is sent and every report has arrived, then lets
  // the block finish any scan still running for a word with no report.
  task automatic wait_idle();
    while (report_blocks_to_send.size() > 0 || s_axis_tvalid ||
           loss_reports_due.size() > 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic queue_random(input int target);
    int   first;
    bit   held;
    int   nblk;
    int   idx;
    int   adv;
    int   lost_step;
    int   pick;
    logic last;
    first = n_useful;
    held = 1'b0;
    while (n_useful - first < target) begin
      if (!held && n_useful - first >= target / 2) begin
        hold_next = 1'b1;
        held = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // Well-formed report: sequences advance and losses mostly trail them.
        nblk = $urandom_range(1, 4);
        for (int k = 0; k < nblk; k++) begin
          idx = $urandom_range(0, PoolSize - 1);
          case ($urandom_range(0, 9))
            0:       adv = 0;
            1:       adv = $urandom_range(1000, 100000);
            default: adv = $urandom_range(1, 400);
          endcase
          if ($urandom_range(0, 7) == 0) lost_step = -$urandom_range(1, 3);
          else lost_step = $urandom_range(0, adv / 2);
          last = (k == nblk - 1);
          queue_pool(idx, adv, lost_step, last, last ? next_report_ms() : rand48());
        end
      end else if (pick < 85) begin
        // Broken report: arbitrary jumps in sequence and loss.
        nblk = $urandom_range(1, 3);
        for (int k = 0; k < nblk; k++) begin
          idx = $urandom_range(0, PoolSize - 1);
          last = (k == nblk - 1);
          queue_pool(idx, $urandom, $urandom, last, last ? next_report_ms() : rand48());
        end
      end else begin
        // Block from a source the full table cannot take.
        last = ($urandom_range(0, 3) == 0);
        if (last) n_useful++;
        queue_block($urandom, $urandom, $urandom, last ? next_report_ms() : rand48(), last);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Pool sources 2 and up differ in the low nibble; the first two are the extremes.
    pool_src[0] = '0;
    pool_src[1] = '1;
    for (int i = 2; i < PoolSize; i++) begin
      pool_src[i]  = ($urandom & 32'hFFFF_FFF0) | i;
      pool_seq[i]  = $urandom;
      pool_lost[i] = $urandom;
    end
    pool_seq[0]  = '0;
    pool_lost[0] = 32'h8000_0000;
    pool_seq[1]  = 32'hFFFF_FFF0;
    pool_lost[1] = 32'h7FFF_FFFF;

    // Directed part, controller present.
    set_controller(1'b1);
    // New source closing a report with nothing summed: no report.
    queue_pool(0, 0, 0, 1'b1, '1);
    queue_pool(1, 0, 0, 1'b0, '0);
    // The sequence of this source wraps past the top; its loss passes the signed maximum.
    queue_pool(1, 32'h20, 5, 1'b0, '0);
    queue_pool(0, 100, 10, 1'b1, 48'd1000);
    // More losses than packets: received count below one.
    queue_pool(2, 0, 0, 1'b0, rand48());
    queue_pool(2, 50, 60, 1'b1, 48'd2000);
    // Losses equal to the advance: received count of zero.
    queue_pool(2, 40, 40, 1'b1, 48'd3000);
    for (int i = 3; i < PoolSize; i++)
      queue_pool(i, 0, 0, (i == PoolSize - 1), rand48());
    // Table is full now, so this source is dropped.
    queue_block(32'hA5A5_C3C0, $urandom, $urandom, rand48(), 1'b0);
    // Same source twice in one report.
    queue_pool(3, 7, 0, 1'b0, rand48());
    queue_pool(3, 9, 3, 1'b1, 48'd4000);
    wait_idle();

    // Without a controller a passing report still moves the window end.
    set_controller(1'b0);
    queue_pool(0, 5, 0, 1'b1, 48'd5000);
    wait_idle();

    set_controller(1'b1);
    // Largest received count, then a negative loss delta.
    queue_pool(4, 32'h7FFF_FFFF, 0, 1'b1, '1);
    queue_pool(5, 1, 32'hFFFF_FFFF, 1'b1, '0);

    // Random part over alternating controller settings.
    wait_idle();
    set_controller(1'b1);
    queue_random(500);
    wait_idle();
    set_controller(1'b0);
    queue_random(250);
    wait_idle();
    set_controller(1'b1);
    queue_random(450);
    wait_idle();
    set_controller(1'b0);
    queue_random(200);
    wait_idle();
    set_controller(1'b1);
    queue_random(500);
    wait_idle();

    $display("Run covered %0d report blocks and %0d loss reports over %0d controller writes,",
             n_accepted, n_reports, n_cfg_writes);
    $display("including table fill, table full, counter wrap and rejected report sums.");
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d words pending and %0d reports due",
             report_blocks_to_send.size(), loss_reports_due.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
